// File: rtl/adsr_pkg.sv
package adsr_pkg;

   // field and register widths
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEF_BITS_DEF   = 24;
   localparam int HOLD_BITS       = 24;

   // register reset values, Q0.24 where fractional
   localparam int unsigned ATTACK_STEP_RST    = 32'd16777;
   localparam int unsigned DECAY_FACTOR_RST   = 32'd16760438;
   localparam int unsigned SUSTAIN_LEVEL_RST  = 32'd8388608;
   localparam int unsigned RELEASE_FACTOR_RST = 32'd16760438;
   localparam int unsigned HOLD_SAMPLES_RST   = 32'd1;

   // register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK_STEP    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAY_FACTOR   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUSTAIN_LEVEL  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_FACTOR = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_SAMPLES   = 3'd4;

   // phase flag bit positions
   localparam int FLAG_BITS    = 4;
   localparam int FLAG_ATTACK  = 0;
   localparam int FLAG_DECAY   = 1;
   localparam int FLAG_SUSTAIN = 2;
   localparam int FLAG_RELEASE = 3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENTRY,
      ST_DECAY,
      ST_DECAY_MUL,
      ST_HOLD,
      ST_GATE,
      ST_RELEASE,
      ST_RELEASE_MUL,
      ST_SCALE,
      ST_SCALE_MUL,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/adsr_serial_mul.sv
// serial-parallel multiplier: one multiplier bit per cycle, lsb first
// product = floor(mcand * mplier / 2^(MPLIER_BITS-1))
module adsr_serial_mul #(
   parameter int MCAND_BITS  = 25,
   parameter int MPLIER_BITS = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [MCAND_BITS-1:0] mcand,
   input  logic        [MPLIER_BITS-1:0] mplier,
   output logic                         done,
   output logic signed [MCAND_BITS:0]   product
);

   localparam int CNT_BITS = $clog2(MPLIER_BITS);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic [MPLIER_BITS-1:0]      mplier_ff, mplier_in;
   logic signed [MCAND_BITS-1:0] mcand_ff, mcand_in;
   logic signed [MCAND_BITS:0]  acc_ff, acc_in;
   logic signed [MCAND_BITS:0]  addend;
   logic signed [MCAND_BITS:0]  sum;

   always_comb begin
      addend    = mplier_ff[0] ? {mcand_ff[MCAND_BITS-1], mcand_ff} : '0;
      sum       = acc_ff + addend;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = CNT_BITS'(MPLIER_BITS - 1);
         mplier_in = mplier;
         mcand_in  = mcand;
         acc_in    = '0;
      end else if (busy_ff) begin
         mplier_in = mplier_ff >> 1;
         if (cnt_ff != '0) begin
            acc_in = sum >>> 1;
            cnt_in = cnt_ff - 1'b1;
         end else begin
            // top bit: no shift, keeps the result scaled by 2^-(MPLIER_BITS-1)
            acc_in  = sum;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier restarted while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while still busy");
`endif

endmodule

// File: rtl/adsr_envelope_gain.sv
// channel  | handshake               | payload
// req      | req_valid / req_ready   | req_sample_in, req_gate
// rsp      | rsp_valid / rsp_ready   | rsp_sample_out
// csr      | csr_we (no wait)        | csr_index, csr_wdata
//
// one word at a time: 0 to 3 multiplies per word (decay, release, output scaling),
// all done on the one serial multiplier.
// synchronous active-high reset clears the envelope state and loads register defaults.
// a finished word waits in the output register; the next req word is taken meanwhile.
module adsr_envelope_gain #(
   parameter int SAMPLE_BITS = adsr_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = adsr_pkg::COEF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input words
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          req_gate,
   // result words
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   // register writes
   input  logic                          csr_we,
   input  logic [adsr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((COEF_BITS+1 > adsr_pkg::HOLD_BITS) ? COEF_BITS+1
                  : adsr_pkg::HOLD_BITS)-1:0] csr_wdata
);

   localparam int AMP_BITS    = COEF_BITS + 1;
   localparam int HOLD_BITS   = adsr_pkg::HOLD_BITS;
   // multiplicand holds a signed sample or a zero-extended coefficient
   localparam int MCAND_BITS  = ((SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS) + 1;
   localparam logic [AMP_BITS:0] ONE_WIDE = (AMP_BITS+1)'(1) << COEF_BITS;
   localparam logic [AMP_BITS-1:0] ONE    = AMP_BITS'(1) << COEF_BITS;

   // configuration registers
   logic [AMP_BITS-1:0]  attack_step_ff;
   logic [COEF_BITS-1:0] decay_factor_ff;
   logic [AMP_BITS-1:0]  sustain_level_ff;
   logic [COEF_BITS-1:0] release_factor_ff;
   logic [HOLD_BITS-1:0] hold_samples_ff;

   // envelope state
   adsr_pkg::state_type               state_ff, state_in;
   logic [adsr_pkg::FLAG_BITS-1:0]    flags_ff, flags_in;
   logic [AMP_BITS-1:0]               amp_ff, amp_in;
   logic [HOLD_BITS-1:0]              hold_count_ff, hold_count_in;
   logic signed [SAMPLE_BITS-1:0]     last_out_ff, last_out_in;

   // per-word working registers
   logic signed [SAMPLE_BITS-1:0]     sample_ff, sample_in;
   logic                              gate_ff, gate_in;
   logic                              wrote_ff, wrote_in;     // some phase updated the output

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]     rsp_sample_out_ff, rsp_sample_out_in;

   // multiplier hookup
   logic                              mul_start;
   logic signed [MCAND_BITS-1:0]      mul_mcand;
   logic [AMP_BITS-1:0]               mul_mplier;
   logic                              mul_done;
   logic signed [MCAND_BITS:0]        mul_product;

   logic [AMP_BITS:0]                 attack_sum;
   logic                              req_take;
   logic                              rsp_load;

   adsr_serial_mul #(
      .MCAND_BITS  (MCAND_BITS),
      .MPLIER_BITS (AMP_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_product)
   );

   // register writes, values truncated to register width
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff    <= AMP_BITS'(adsr_pkg::ATTACK_STEP_RST);
         decay_factor_ff   <= COEF_BITS'(adsr_pkg::DECAY_FACTOR_RST);
         sustain_level_ff  <= AMP_BITS'(adsr_pkg::SUSTAIN_LEVEL_RST);
         release_factor_ff <= COEF_BITS'(adsr_pkg::RELEASE_FACTOR_RST);
         hold_samples_ff   <= HOLD_BITS'(adsr_pkg::HOLD_SAMPLES_RST);
      end else if (csr_we) begin
         case (csr_index)
            adsr_pkg::CSR_ATTACK_STEP:    attack_step_ff    <= csr_wdata[AMP_BITS-1:0];
            adsr_pkg::CSR_DECAY_FACTOR:   decay_factor_ff   <= csr_wdata[COEF_BITS-1:0];
            adsr_pkg::CSR_SUSTAIN_LEVEL:  sustain_level_ff  <= csr_wdata[AMP_BITS-1:0];
            adsr_pkg::CSR_RELEASE_FACTOR: release_factor_ff <= csr_wdata[COEF_BITS-1:0];
            adsr_pkg::CSR_HOLD_SAMPLES:   hold_samples_ff   <= csr_wdata[HOLD_BITS-1:0];
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   assign req_ready = (state_ff == adsr_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign attack_sum = {1'b0, amp_ff} + {1'b0, attack_step_ff};

   // phase sequencer: each state is one step of the envelope update
   always_comb begin
      state_in          = state_ff;
      flags_in          = flags_ff;
      amp_in            = amp_ff;
      hold_count_in     = hold_count_ff;
      last_out_in       = last_out_ff;
      sample_in         = sample_ff;
      gate_in           = gate_ff;
      wrote_in          = wrote_ff;
      rsp_load          = 1'b0;
      mul_start         = 1'b0;
      mul_mcand         = {{(MCAND_BITS-COEF_BITS){1'b0}}, decay_factor_ff};
      mul_mplier        = amp_ff;

      case (state_ff)
         adsr_pkg::ST_IDLE: begin
            if (req_take) begin
               sample_in = req_sample_in;
               gate_in   = req_gate;
               wrote_in  = 1'b0;
               state_in  = adsr_pkg::ST_ENTRY;
            end
         end
         adsr_pkg::ST_ENTRY: begin
            // key down outside attack, decay and sustain restarts the attack
            if (gate_ff && !flags_ff[adsr_pkg::FLAG_ATTACK] &&
                !flags_ff[adsr_pkg::FLAG_DECAY] && !flags_ff[adsr_pkg::FLAG_SUSTAIN]) begin
               hold_count_in = '0;
               flags_in      = '0;
               flags_in[adsr_pkg::FLAG_ATTACK] = 1'b1;
               // attack sees the amplitude as it stands
            end
            if (flags_in[adsr_pkg::FLAG_ATTACK]) begin
               flags_in[adsr_pkg::FLAG_RELEASE] = 1'b0;
               wrote_in = 1'b1;
               if (attack_sum >= ONE_WIDE) begin
                  amp_in = ONE;
                  flags_in[adsr_pkg::FLAG_ATTACK] = 1'b0;
                  flags_in[adsr_pkg::FLAG_DECAY]  = 1'b1;
               end else begin
                  amp_in = attack_sum[AMP_BITS-1:0];
               end
            end
            state_in = adsr_pkg::ST_DECAY;
         end
         adsr_pkg::ST_DECAY: begin
            if (flags_ff[adsr_pkg::FLAG_DECAY]) begin
               mul_start = 1'b1;
               state_in  = adsr_pkg::ST_DECAY_MUL;
            end else begin
               state_in  = adsr_pkg::ST_HOLD;
            end
         end
         adsr_pkg::ST_DECAY_MUL: begin
            if (mul_done) begin
               amp_in   = mul_product[AMP_BITS-1:0];
               wrote_in = 1'b1;
               if (mul_product[AMP_BITS-1:0] <= sustain_level_ff) begin
                  flags_in[adsr_pkg::FLAG_DECAY]   = 1'b0;
                  flags_in[adsr_pkg::FLAG_SUSTAIN] = 1'b1;
               end
               state_in = adsr_pkg::ST_HOLD;
            end
         end
         adsr_pkg::ST_HOLD: begin
            if (hold_count_ff < hold_samples_ff && flags_ff[adsr_pkg::FLAG_SUSTAIN]) begin
               wrote_in      = 1'b1;
               hold_count_in = hold_count_ff + 1'b1;
            end
            state_in = adsr_pkg::ST_GATE;
         end
         adsr_pkg::ST_GATE: begin
            // hold time met: key down keeps the level, key up starts release
            if (hold_count_ff >= hold_samples_ff) begin
               if (gate_ff) begin
                  wrote_in = 1'b1;
               end else begin
                  flags_in[adsr_pkg::FLAG_SUSTAIN] = 1'b0;
                  flags_in[adsr_pkg::FLAG_RELEASE] = 1'b1;
               end
            end
            state_in = adsr_pkg::ST_RELEASE;
         end
         adsr_pkg::ST_RELEASE: begin
            mul_mcand = {{(MCAND_BITS-COEF_BITS){1'b0}}, release_factor_ff};
            if (flags_ff[adsr_pkg::FLAG_RELEASE] && amp_ff != '0) begin
               mul_start = 1'b1;
               state_in  = adsr_pkg::ST_RELEASE_MUL;
            end else begin
               state_in  = adsr_pkg::ST_SCALE;
            end
         end
         adsr_pkg::ST_RELEASE_MUL: begin
            if (mul_done) begin
               amp_in   = mul_product[AMP_BITS-1:0];
               wrote_in = 1'b1;
               state_in = adsr_pkg::ST_SCALE;
            end
         end
         adsr_pkg::ST_SCALE: begin
            // output is scaled once, by the final amplitude of this word
            mul_mcand = {{(MCAND_BITS-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff};
            if (wrote_ff) begin
               mul_start = 1'b1;
               state_in  = adsr_pkg::ST_SCALE_MUL;
            end else begin
               state_in  = adsr_pkg::ST_FINISH;
            end
         end
         adsr_pkg::ST_SCALE_MUL: begin
            if (mul_done) begin
               last_out_in = mul_product[SAMPLE_BITS-1:0];
               state_in    = adsr_pkg::ST_FINISH;
            end
         end
         adsr_pkg::ST_FINISH: begin
            // hand over once the output register is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = adsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = adsr_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in      = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_sample_out_in = rsp_load ? last_out_ff : rsp_sample_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= adsr_pkg::ST_IDLE;
         flags_ff      <= '0;
         amp_ff        <= '0;
         hold_count_ff <= '0;
         last_out_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flags_ff      <= flags_in;
         amp_ff        <= amp_in;
         hold_count_ff <= hold_count_in;
         last_out_ff   <= last_out_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff         <= sample_in;
      gate_ff           <= gate_in;
      wrote_ff          <= wrote_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

`ifndef ASSERT_OFF
   a_amp_max: assert property (@(posedge clock) disable iff (reset)
      amp_ff <= ONE)
      else $error("amplitude above unity");

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0(flags_ff[adsr_pkg::FLAG_SUSTAIN:adsr_pkg::FLAG_ATTACK]))
      else $error("attack, decay and sustain overlap");

   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == adsr_pkg::ST_DECAY_MUL ||
                    state_ff == adsr_pkg::ST_RELEASE_MUL ||
                    state_ff == adsr_pkg::ST_SCALE_MUL))
      else $error("multiplier result arrived with nobody waiting");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output word overwritten before it was taken");
`endif

endmodule
